FILE: sv/z85pd_pkg.sv
// Shared types, codes and lookup functions for the padded Z85 decoder.
// Depends on nothing; every other file of the block uses it.
package z85pd_pkg;

  localparam int unsigned GROUP_CHARS = 5;
  localparam int unsigned GROUP_BYTES = 4;
  localparam logic [7:0] MAX_PAD = 8'd4;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_out;
    logic [1:0] status;
  } out_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
  localparam logic [1:0] STATUS_BAD_PAD = 2'd2;

  // One group of results from one request: up to four bytes of a word,
  // or a single empty result.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        has_data;
    logic        is_last;
    logic [1:0]  status;
  } grp_t;

  // Z85 alphabet: value of a character, 0 for anything outside it.
  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    logic [7:0] tmp;
    logic [6:0] v;
    tmp = 8'd0;
    v   = 7'd0;
    case (c) inside
      ["0":"9"]: begin
        tmp = c - 8'h30;
        v   = tmp[6:0];
      end
      ["a":"z"]: begin
        tmp = c - 8'h61 + 8'd10;
        v   = tmp[6:0];
      end
      ["A":"Z"]: begin
        tmp = c - 8'h41 + 8'd36;
        v   = tmp[6:0];
      end
      ".": v = 7'd62;
      "-": v = 7'd63;
      ":": v = 7'd64;
      "+": v = 7'd65;
      "=": v = 7'd66;
      "^": v = 7'd67;
      "!": v = 7'd68;
      "/": v = 7'd69;
      "*": v = 7'd70;
      "?": v = 7'd71;
      "&": v = 7'd72;
      "<": v = 7'd73;
      ">": v = 7'd74;
      "(": v = 7'd75;
      ")": v = 7'd76;
      "[": v = 7'd77;
      "]": v = 7'd78;
      "{": v = 7'd79;
      "}": v = 7'd80;
      "@": v = 7'd81;
      "%": v = 7'd82;
      "$": v = 7'd83;
      "#": v = 7'd84;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // Place weight of a character within its group (85^4 down to 1).
  function automatic logic [31:0] place_weight(input logic [2:0] pos);
    logic [31:0] w;
    case (pos)
      3'd0:    w = 32'd52200625;
      3'd1:    w = 32'd614125;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd85;
      3'd4:    w = 32'd1;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/z85pd_in_stage.sv
// Input register of the padded Z85 decoder: holds one request for the
// decode stage. Depends on z85pd_pkg.
module z85pd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  z85pd_pkg::in_t  in_data,
  output logic            item_valid,
  output z85pd_pkg::in_t  item,
  input  logic            take
);

  logic           valid_r;
  logic           valid_nxt;
  z85pd_pkg::in_t data_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

FILE: sv/z85pd_decode.sv
// Decode stage: header handling, character accumulation and result grouping.
// Depends on z85pd_pkg.
module z85pd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  z85pd_pkg::in_t  item,
  output logic            take,
  output logic            push,
  output z85pd_pkg::grp_t grp,
  input  logic            grp_ready
);

  logic        awaiting_r, awaiting_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic        bad_r, bad_nxt;

  logic [2:0]  pos_cur;
  logic [2:0]  pos_inc;
  logic [31:0] acc_sum;
  logic [31:0] product;
  logic [2:0]  keep;
  logic        produces;

  assign pos_cur = (pos_r > 3'd4) ? 3'd0 : pos_r;
  assign pos_inc = pos_cur + 3'd1;
  assign product = {25'd0, z85pd_pkg::symbol_value(item.char_byte)}
                   * z85pd_pkg::place_weight(pos_cur);
  assign acc_sum = acc_r + product;
  assign keep    = 3'd4 - pad_r;

  always_comb begin
    produces = 1'b0;
    grp      = '{word: acc_sum, count: 3'd1, has_data: 1'b0, is_last: 1'b0,
                 status: z85pd_pkg::STATUS_OK};
    if (awaiting_r) begin
      produces = item.last_in;
      grp.word    = 32'd0;
      grp.is_last = 1'b1;
      grp.status  = (item.char_byte > z85pd_pkg::MAX_PAD) ?
                    z85pd_pkg::STATUS_BAD_PAD : z85pd_pkg::STATUS_OK;
    end else if (!item.last_in) begin
      produces     = (pos_inc == 3'd5);
      grp.count    = 3'd4;
      grp.has_data = 1'b1;
    end else begin
      produces    = 1'b1;
      grp.is_last = 1'b1;
      if (pos_inc != 3'd5) begin
        grp.word   = 32'd0;
        grp.status = z85pd_pkg::STATUS_BAD_LEN;
      end else if (bad_r) begin
        grp.word   = 32'd0;
        grp.status = z85pd_pkg::STATUS_BAD_PAD;
      end else if (keep == 3'd0) begin
        grp.word = 32'd0;
      end else begin
        grp.count    = keep;
        grp.has_data = 1'b1;
      end
    end
  end

  // Requests that yield nothing never wait on the serializer.
  assign take = item_valid && (!produces || grp_ready);
  assign push = take && produces;

  always_comb begin
    awaiting_nxt = awaiting_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    pad_nxt      = pad_r;
    bad_nxt      = bad_r;
    if (take) begin
      if (awaiting_r) begin
        bad_nxt      = (item.char_byte > z85pd_pkg::MAX_PAD);
        pad_nxt      = bad_nxt ? 3'd0 : item.char_byte[2:0];
        pos_nxt      = 3'd0;
        acc_nxt      = 32'd0;
        awaiting_nxt = item.last_in;
      end else if (item.last_in) begin
        awaiting_nxt = 1'b1;
        pos_nxt      = 3'd0;
        acc_nxt      = 32'd0;
        pad_nxt      = 3'd0;
        bad_nxt      = 1'b0;
      end else if (pos_inc == 3'd5) begin
        pos_nxt = 3'd0;
        acc_nxt = 32'd0;
      end else begin
        pos_nxt = pos_inc;
        acc_nxt = acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      pos_r      <= 3'd0;
      acc_r      <= 32'd0;
      pad_r      <= 3'd0;
      bad_r      <= 1'b0;
    end else begin
      awaiting_r <= awaiting_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      pad_r      <= pad_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

FILE: sv/z85pd_serializer.sv
// Result register and byte serializer: sends a group's results one a cycle
// while out_ready is high. Depends on z85pd_pkg.
module z85pd_serializer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  z85pd_pkg::grp_t grp,
  output logic            grp_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output z85pd_pkg::out_t out_data
);

  logic            valid_r, valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  z85pd_pkg::grp_t grp_r;
  logic            at_final;
  logic [7:0]      sel_byte;

  assign at_final  = ({1'b0, idx_r} == (grp_r.count - 3'd1));
  assign grp_ready = !valid_r || (out_ready && at_final);
  assign out_valid = valid_r;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = grp_r.word[31:24];
      2'd1:    sel_byte = grp_r.word[23:16];
      2'd2:    sel_byte = grp_r.word[15:8];
      default: sel_byte = grp_r.word[7:0];
    endcase
  end

  always_comb begin
    out_data.data_byte  = grp_r.has_data ? sel_byte : 8'd0;
    out_data.byte_valid = grp_r.has_data;
    out_data.last_out   = grp_r.is_last && at_final;
    out_data.status     = (grp_r.is_last && at_final) ? grp_r.status
                                                      : z85pd_pkg::STATUS_OK;
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (push) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (valid_r && out_ready) begin
      if (at_final) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_r <= grp;
    end
  end

endmodule

FILE: sv/z85_padded_decoder_unit.sv
// Top level of the padded Z85 decoder: input register, decode stage, serializer.
// Depends on z85pd_pkg, z85pd_in_stage, z85pd_decode and z85pd_serializer.
//
// Decodes a padded Z85 message that arrives one byte per request: a padding
// count (0..4) first, then Z85 characters in groups of five. Each full group
// gives four big-endian bytes; the final group drops as many trailing bytes
// as the padding count says. The last result of a message has last_out set
// and carries status: bad length (character count not a multiple of five)
// ranks before bad padding (header above four). Bytes already sent before an
// error must be dropped downstream. A message that yields no final bytes ends
// with one empty result (byte_valid = 0, data_byte = 0).
// Rate: one request per cycle unless a result waits on the serializer. A
// request is held in the input register; the decode logic (symbol lookup,
// one constant multiply, 32-bit add) is combinational between it and the
// result register, from which results are offered.
// Results leave one per cycle while out_ready is high; five characters per
// group keep the serializer ahead of the input.
// Requests that yield no result are never held back by the serializer.
module z85_padded_decoder_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  z85pd_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output z85pd_pkg::out_t out_data
);

  logic            item_valid;
  z85pd_pkg::in_t  item;
  logic            take;
  logic            push;
  z85pd_pkg::grp_t grp;
  logic            grp_ready;

  z85pd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // Message state lives here: header flag, group position, accumulator.
  z85pd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .push       (push),
    .grp        (grp),
    .grp_ready  (grp_ready)
  );

  // Holds one group and streams it out; reloads as its last result leaves.
  z85pd_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: dv/tb_z85_padded_decoder_unit.sv
// Self-checking testbench for z85_padded_decoder_unit: a directed part, then random
// padded Z85 messages under several idle and stall mixes. Depends on z85pd_pkg and the RTL.
module tb_z85_padded_decoder_unit;

  // Z85 symbol set and the place weights of a five-character group.
  localparam string Z85_ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
  localparam logic [31:0] Z85_WEIGHT [5] = '{32'd52200625, 32'd614125, 32'd7225, 32'd85,
                                             32'd1};

  // Per phase: no idling, sender idle, receiver stalling, both.
  localparam int NUM_PHASES = 4;
  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 59, 0, 34};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 59, 34};
  localparam int RANDOM_ITEMS_PER_PHASE = 56;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  z85pd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  z85pd_pkg::out_t out_data;

  z85_padded_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Requests waiting to be offered, and decoded results still owed by the block.
  z85pd_pkg::in_t  char_q[$];
  z85pd_pkg::out_t decoded_q[$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int   mismatches = 0;
  z85pd_pkg::out_t want;

  // Decoder state as the block should hold it.
  logic        hdr_wait = 1'b1;
  logic [2:0]  char_pos = '0;
  logic [31:0] word_acc = '0;
  logic [2:0]  pad_cnt = '0;
  logic        pad_bad = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // Symbol value; anything outside the set decodes as zero.
  function automatic logic [6:0] z85_value(input logic [7:0] c);
    logic [6:0] v;
    v = '0;
    for (int i = 0; i < 85; i++) begin
      if (Z85_ALPHABET[i] == c) begin
        v = i[6:0];
      end
    end
    return v;
  endfunction

  function automatic z85pd_pkg::out_t mk_result(input logic [7:0] data, input logic valid,
                                                input logic last, input logic [1:0] status);
    z85pd_pkg::out_t r;
    r.data_byte  = data;
    r.byte_valid = valid;
    r.last_out   = last;
    r.status     = status;
    return r;
  endfunction

  // Advance the decoder by one accepted request and queue what it yields.
  task automatic decode_char(input z85pd_pkg::in_t req);
    int keep;
    if (hdr_wait) begin
      // Header: padding count; anything above four is flagged and treated as zero.
      pad_bad  = req.char_byte > z85pd_pkg::MAX_PAD;
      pad_cnt  = pad_bad ? 3'd0 : req.char_byte[2:0];
      char_pos = '0;
      word_acc = '0;
      hdr_wait = 1'b0;
      if (req.last_in) begin
        // Header-only message: one empty result.
        decoded_q.push_back(mk_result(8'd0, 1'b0, 1'b1,
                                      pad_bad ? z85pd_pkg::STATUS_BAD_PAD
                                              : z85pd_pkg::STATUS_OK));
        hdr_wait = 1'b1;
      end
    end else begin
      // Word wraps modulo 2^32.
      word_acc = word_acc + z85_value(req.char_byte) * Z85_WEIGHT[char_pos];
      char_pos = char_pos + 3'd1;
      if (!req.last_in) begin
        if (char_pos == z85pd_pkg::GROUP_CHARS) begin
          for (int j = 0; j < z85pd_pkg::GROUP_BYTES; j++) begin
            decoded_q.push_back(mk_result(word_acc[8 * (3 - j) +: 8], 1'b1, 1'b0,
                                          z85pd_pkg::STATUS_OK));
          end
          char_pos = '0;
          word_acc = '0;
        end
      end else begin
        if (char_pos != z85pd_pkg::GROUP_CHARS) begin
          // Incomplete final group wins over a bad header.
          decoded_q.push_back(mk_result(8'd0, 1'b0, 1'b1, z85pd_pkg::STATUS_BAD_LEN));
        end else if (pad_bad) begin
          decoded_q.push_back(mk_result(8'd0, 1'b0, 1'b1, z85pd_pkg::STATUS_BAD_PAD));
        end else begin
          keep = z85pd_pkg::GROUP_BYTES - pad_cnt;
          for (int j = 0; j < keep; j++) begin
            decoded_q.push_back(mk_result(word_acc[8 * (3 - j) +: 8], 1'b1,
                                          j == keep - 1, z85pd_pkg::STATUS_OK));
          end
          // Fully padded final group leaves nothing: close with an empty result.
          if (keep == 0) begin
            decoded_q.push_back(mk_result(8'd0, 1'b0, 1'b1, z85pd_pkg::STATUS_OK));
          end
        end
        hdr_wait = 1'b1;
        char_pos = '0;
        word_acc = '0;
        pad_cnt  = '0;
        pad_bad  = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] c, input logic last);
    z85pd_pkg::in_t r;
    r.char_byte = c;
    r.last_in   = last;
    char_q.push_back(r);
  endtask

  // Characters of s in order; the final one ends the message when end_msg is set.
  task automatic push_text(input string s, input logic end_msg);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], end_msg && (i == s.len() - 1));
    end
  endtask

  // Mostly well-formed messages; some carry a bad header, a short final group
  // or bytes outside the symbol set.
  task automatic queue_random_message();
    logic [7:0] hdr;
    logic [7:0] c;
    int groups;
    int tail;
    int nchars;
    hdr    = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
    groups = $urandom_range(4);
    tail   = ($urandom_range(6) == 0) ? $urandom_range(1, 4) : 0;
    nchars = groups * z85pd_pkg::GROUP_CHARS + tail;
    push_char(hdr, nchars == 0);
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(99) < 85) begin
        c = Z85_ALPHABET[$urandom_range(84)];
      end else begin
        c = 8'($urandom_range(255));
      end
      push_char(c, i == nchars - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests; valid and payload hold until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_char(in_data);
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result: data=%h valid=%b last=%b status=%0d",
                     out_data.data_byte, out_data.byte_valid, out_data.last_out,
                     out_data.status);
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_data.data_byte !== want.data_byte || out_data.byte_valid !== want.byte_valid
              || out_data.last_out !== want.last_out || out_data.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch: expected data=%h valid=%b last=%b status=%0d",
                       want.data_byte, want.byte_valid, want.last_out, want.status);
              $display("          got      data=%h valid=%b last=%b status=%0d",
                       out_data.data_byte, out_data.byte_valid, out_data.last_out,
                       out_data.status);
            end
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off early in the no-idle phase: the sender keeps
  // offering, so the block fills up and must drop in_ready.
  initial begin
    @(posedge rst_n);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, then phases; each phase drains before the next.
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      if (ph == 0) begin
        // Header alone, good and bad.
        push_char(8'd0, 1'b1);
        push_char(8'hFF, 1'b1);
        // Largest group value: wraps modulo 2^32, all four bytes kept.
        push_char(8'd0, 1'b0);
        push_text("#####", 1'b1);
        // Padding of four with bytes outside the set: empty closing result.
        push_char(8'd4, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'h7E, 1'b0);
        push_char(8'h22, 1'b0);
        push_char("0", 1'b1);
        // Short final group with a bad header too: length error ranks first.
        push_char(8'd7, 1'b0);
        push_text("aZ.", 1'b1);
        // Complete group under a bad header: padding error.
        push_char(8'd9, 1'b0);
        push_char(8'h7F, 1'b0);
        push_text("az9Z", 1'b1);
      end
      base = char_q.size();
      while (char_q.size() - base < RANDOM_ITEMS_PER_PHASE) begin
        queue_random_message();
      end
      while (char_q.size() != 0 || in_valid || decoded_q.size() != 0) begin
        @(negedge clk);
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("z85_padded_decoder_unit verification clean");
    end else begin
      $display("z85_padded_decoder_unit verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("z85_padded_decoder_unit verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/z85pd_pkg.sv
sv/z85pd_in_stage.sv
sv/z85pd_decode.sv
sv/z85pd_serializer.sv
sv/z85_padded_decoder_unit.sv
dv/tb_z85_padded_decoder_unit.sv
